// ===== hdl/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants of the sorted min-first priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam logic signed [DATA_W-1:0] UNDERFLOW_VALUE = -32'sd1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PLACE = 5'b00100,
    S_HEAD  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded min-first priority queue kept as an ascending circular buffer in
// one memory. Equal values leave in arrival order.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  request  | in_valid / in_stall   | cmd, value_in
//  result   | out_valid / out_stall | status, removed_value, smallest_value,
//           |                       | largest_value, entry_count
//
//  Overflow, underflow, an insert at the tail and a remove that empties the
//  queue go straight to the result; any other remove first reads the new
//  head from memory. An insert below the tail walks the store from the tail,
//  one entry a cycle on the single read port, whether or not it becomes the
//  new head. Reset empties the queue at once (no clearing pass).
//  A new request is taken while a result waits; the next result holds until
//  the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_min_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               cmd,
  input  wire logic signed [smpq_pkg::DATA_W-1:0] value_in,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              status,
  output logic signed [smpq_pkg::DATA_W-1:0]      removed_value,
  output logic signed [smpq_pkg::DATA_W-1:0]      smallest_value,
  output logic signed [smpq_pkg::DATA_W-1:0]      largest_value,
  output logic [smpq_pkg::COUNT_OUT_W-1:0]        entry_count
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    return (a == '0) ? LAST_ADDR : a - 1'b1;
  endfunction

  smpq_pkg::state_t state;
  logic [CW-1:0]    count;
  logic [AW-1:0]    head;
  logic [AW-1:0]    tail;
  logic [AW-1:0]    cur;
  logic [CW-1:0]    left;
  logic signed [smpq_pkg::DATA_W-1:0] pend_value;
  logic signed [smpq_pkg::DATA_W-1:0] smallest;
  logic signed [smpq_pkg::DATA_W-1:0] largest;
  smpq_pkg::status_t                  res_status;
  logic signed [smpq_pkg::DATA_W-1:0] res_removed;
  smpq_pkg::status_t                  status_out;

  logic                               we;
  logic [AW-1:0]                      waddr;
  logic signed [smpq_pkg::DATA_W-1:0] wdata;
  logic [AW-1:0]                      raddr;
  logic signed [smpq_pkg::DATA_W-1:0] rdata;

  logic accept;
  logic out_free;
  logic [CW+smpq_pkg::COUNT_OUT_W-1:0] count_ext;

  assign in_stall = (state != smpq_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign status   = status_out;

  smpq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = tail;
    wdata = value_in;
    raddr = addr_dec(tail);
    unique case (state)
      smpq_pkg::S_IDLE: begin
        if (accept && cmd == smpq_pkg::CMD_INSERT && count != FULL_COUNT &&
            (count == '0 || value_in >= largest)) begin
          we = 1'b1;
        end
        if (cmd == smpq_pkg::CMD_REMOVE) begin
          raddr = addr_inc(head);
        end
      end
      smpq_pkg::S_SCAN: begin
        we    = 1'b1;
        waddr = addr_inc(cur);
        wdata = (rdata > pend_value) ? rdata : pend_value;
        raddr = addr_dec(cur);
      end
      smpq_pkg::S_PLACE: begin
        we    = 1'b1;
        waddr = cur;
        wdata = pend_value;
      end
      smpq_pkg::S_HEAD, smpq_pkg::S_DONE: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smpq_pkg::S_IDLE;
      count     <= '0;
      head      <= '0;
      tail      <= '0;
      smallest  <= '0;
      largest   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == smpq_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        smpq_pkg::S_IDLE: begin
          if (accept) begin
            res_removed <= '0;
            res_status  <= smpq_pkg::ST_OK;
            pend_value  <= value_in;
            if (cmd == smpq_pkg::CMD_INSERT) begin
              priority if (count == FULL_COUNT) begin
                res_status <= smpq_pkg::ST_OVERFLOW;
                state      <= smpq_pkg::S_DONE;
              end else if (count == '0 || value_in >= largest) begin
                // Append at the tail: no entry moves.
                count   <= count + 1'b1;
                tail    <= addr_inc(tail);
                largest <= value_in;
                if (count == '0) begin
                  smallest <= value_in;
                end
                state <= smpq_pkg::S_DONE;
              end else begin
                count <= count + 1'b1;
                tail  <= addr_inc(tail);
                cur   <= addr_dec(tail);
                left  <= count;
                if (value_in < smallest) begin
                  smallest <= value_in;
                end
                state <= smpq_pkg::S_SCAN;
              end
            end else begin
              priority if (count == '0) begin
                res_status  <= smpq_pkg::ST_UNDERFLOW;
                res_removed <= smpq_pkg::UNDERFLOW_VALUE;
                state       <= smpq_pkg::S_DONE;
              end else if (count == CW'(1)) begin
                res_removed <= smallest;
                count       <= '0;
                head        <= addr_inc(head);
                smallest    <= '0;
                largest     <= '0;
                state       <= smpq_pkg::S_DONE;
              end else begin
                res_removed <= smallest;
                count       <= count - 1'b1;
                head        <= addr_inc(head);
                state       <= smpq_pkg::S_HEAD;
              end
            end
          end
        end
        smpq_pkg::S_SCAN: begin
          // rdata holds the entry at cur; move it up while it is larger.
          if (rdata > pend_value) begin
            if (left == CW'(1)) begin
              state <= smpq_pkg::S_PLACE;
            end else begin
              cur  <= addr_dec(cur);
              left <= left - 1'b1;
            end
          end else begin
            state <= smpq_pkg::S_DONE;
          end
        end
        smpq_pkg::S_PLACE: begin
          state <= smpq_pkg::S_DONE;
        end
        smpq_pkg::S_HEAD: begin
          smallest <= rdata;
          state    <= smpq_pkg::S_DONE;
        end
        smpq_pkg::S_DONE: begin
          if (out_free) begin
            state <= smpq_pkg::S_IDLE;
          end
        end
        default: begin
          state <= smpq_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign count_ext = {{smpq_pkg::COUNT_OUT_W{1'b0}}, count};

  // Output register: load when the result slot is free.
  always_ff @(posedge clk) begin
    if (state == smpq_pkg::S_DONE && out_free) begin
      status_out     <= res_status;
      removed_value  <= res_removed;
      smallest_value <= smallest;
      largest_value  <= largest;
      entry_count    <= count_ext[smpq_pkg::COUNT_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/smpq_ram.sv =====
// ----------------------------------------------------------------------------
// smpq_ram
// Entry store of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [AW-1:0]                     waddr,
  input  wire logic signed [smpq_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]                     raddr,
  output logic signed [smpq_pkg::DATA_W-1:0]     rdata
);

  logic signed [smpq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
